// File: rtl/core/wum_pkg.sv
// ============================================================================
// wum_pkg: shared types and constants for the wildcard URL matcher
// Pattern store size, derived widths, operation codes and the word structs
// passed between the input stage, the match engine and the result stage.
// ============================================================================
`default_nettype none

package wum_pkg;

    // Pattern store depth and derived widths
    localparam int PATTERN_MAX = 64;
    localparam int POS_W       = PATTERN_MAX + 1;          // active position vector
    localparam int LEN_W       = $clog2(PATTERN_MAX + 1);  // holds 0..PATTERN_MAX
    localparam int IDX_W       = $clog2(PATTERN_MAX);      // store address

    // Wildcard byte in a pattern
    localparam logic [7:0] STAR_BYTE = 8'h2A;

    // Operation codes
    typedef enum logic {
        OP_LOAD    = 1'b0,
        OP_SUBJECT = 1'b1
    } t_op;

    // One input word
    typedef struct packed {
        t_op        operation;
        logic [7:0] char_byte;
        logic       is_last;
    } t_item;

    // One result word
    typedef struct packed {
        logic matched;
        logic pattern_too_long;
    } t_result;

endpackage : wum_pkg

`default_nettype wire

// File: rtl/core/wum_in_stage.sv
// ============================================================================
// wum_in_stage: input register
// Holds one accepted word for the match engine; refills in the same cycle
// the engine takes the held word.
// ============================================================================
`default_nettype none

module wum_in_stage
    import wum_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    output logic       o_ready,
    input  wire t_item i_item,
    output logic       o_item_valid,
    output t_item      o_item,
    input  wire logic  i_pop
);

    logic  r_valid;
    t_item r_item;

    // Room when empty or when the held word leaves this cycle
    assign o_ready      = !r_valid || i_pop;
    assign o_item_valid = r_valid;
    assign o_item       = r_item;

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule : wum_in_stage

`default_nettype wire

// File: rtl/core/wum_engine.sv
// ============================================================================
// wum_engine: pattern store and bit-parallel match update
// Loads pattern bytes into a byte-per-position store and, per subject byte,
// advances the set of active pattern positions.
// ============================================================================
`default_nettype none

module wum_engine
    import wum_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_item_valid,
    input  wire t_item i_item,
    input  wire logic  i_out_free,
    output logic       o_pop,
    output logic       o_res_valid,
    output t_result    o_res
);

    // Pattern store: one byte per position, each compared in its own lane
    logic [7:0]             r_store [PATTERN_MAX];
    logic [PATTERN_MAX-1:0] r_star;
    logic [PATTERN_MAX-1:0] r_valid, n_valid;

    // Pattern and subject state
    logic [LEN_W-1:0] r_len, n_len;
    logic             r_done, n_done;
    logic             r_ovf, n_ovf;
    logic             r_in_subj, n_in_subj;
    logic [POS_W-1:0] r_active, n_active;
    logic [POS_W-1:0] r_init, n_init;    // start set closed over leading stars
    logic [POS_W-1:0] r_end, n_end;      // one-hot of the pattern length

    // Load path
    logic [LEN_W-1:0] b_len;
    logic             b_ovf;
    logic [PATTERN_MAX-1:0] b_valid;
    logic [POS_W-1:0] b_init, b_end;
    logic             is_star, init_hit, wr_en;

    // Subject path
    logic [POS_W-1:0]       a0, nxt, t_prop, x_add, sum, car, clo;
    logic [PATTERN_MAX-1:0] star_v, eq, keep, step;

    logic produce, go;

    assign produce     = i_item_valid && (i_item.operation == OP_SUBJECT) && i_item.is_last;
    assign go          = i_item_valid && (!produce || i_out_free);
    assign o_pop       = go;
    assign o_res_valid = produce && go;

    assign is_star = (i_item.char_byte == STAR_BYTE);
    assign star_v  = r_star & r_valid;

    // Per-lane byte compare
    always_comb begin
        for (int k = 0; k < PATTERN_MAX; k++) begin
            eq[k] = (r_store[k] == i_item.char_byte);
        end
    end

    // Base values for a load: a load after a finished pattern starts over
    always_comb begin
        if (r_done) begin
            b_len   = '0;
            b_ovf   = 1'b0;
            b_valid = '0;
            b_init  = POS_W'(1);
            b_end   = POS_W'(1);
        end else begin
            b_len   = r_len;
            b_ovf   = r_ovf;
            b_valid = r_valid;
            b_init  = r_init;
            b_end   = r_end;
        end
    end

    assign init_hit = |(b_init & b_end);
    assign wr_en    = go && (i_item.operation == OP_LOAD) && !b_end[PATTERN_MAX];

    // Subject step: stars hold their position, matching literals advance
    always_comb begin
        a0     = r_in_subj ? r_active : r_init;
        keep   = a0[PATTERN_MAX-1:0] & star_v;
        step   = a0[PATTERN_MAX-1:0] & r_valid & ~r_star & eq;
        nxt    = {1'b0, keep} | {step, 1'b0};
        // Closure over star runs as a carry chain: star at k propagates into k+1
        t_prop = {star_v, 1'b0};
        x_add  = nxt | t_prop;
        sum    = x_add + nxt;
        car    = sum ^ x_add ^ nxt;
        clo    = nxt | (t_prop & car);
    end

    // Next state
    always_comb begin
        n_len     = r_len;
        n_done    = r_done;
        n_ovf     = r_ovf;
        n_in_subj = r_in_subj;
        n_active  = r_active;
        n_init    = r_init;
        n_end     = r_end;
        n_valid   = r_valid;
        if (go) begin
            case (i_item.operation)
                OP_LOAD: begin
                    n_done    = i_item.is_last;
                    n_in_subj = r_done ? 1'b0 : r_in_subj;
                    n_active  = r_done ? '0 : r_active;
                    n_len     = b_len;
                    n_ovf     = b_ovf;
                    n_valid   = b_valid;
                    n_init    = b_init;
                    n_end     = b_end;
                    if (b_end[PATTERN_MAX]) begin
                        n_ovf = 1'b1;
                    end else begin
                        n_len   = b_len + LEN_W'(1);
                        n_valid = b_valid | b_end[PATTERN_MAX-1:0];
                        n_end   = {b_end[POS_W-2:0], 1'b0};
                        if (is_star && init_hit) begin
                            n_init = b_init | {b_end[POS_W-2:0], 1'b0};
                        end
                    end
                end
                default: begin
                    n_done    = 1'b1;
                    n_active  = clo;
                    n_in_subj = !i_item.is_last;
                end
            endcase
        end
    end

    // Result word
    always_comb begin
        o_res.matched          = !r_ovf && |(clo & r_end);
        o_res.pattern_too_long = r_ovf;
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len     <= '0;
            r_done    <= 1'b1;
            r_ovf     <= 1'b0;
            r_in_subj <= 1'b0;
            r_active  <= '0;
            r_init    <= POS_W'(1);
            r_end     <= POS_W'(1);
            r_valid   <= '0;
        end else begin
            r_len     <= n_len;
            r_done    <= n_done;
            r_ovf     <= n_ovf;
            r_in_subj <= n_in_subj;
            r_active  <= n_active;
            r_init    <= n_init;
            r_end     <= n_end;
            r_valid   <= n_valid;
        end
    end

    // Pattern store write at the current length
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_store[b_len[IDX_W-1:0]] <= i_item.char_byte;
            r_star[b_len[IDX_W-1:0]]  <= is_star;
        end
    end

endmodule : wum_engine

`default_nettype wire

// File: rtl/core/wum_out_stage.sv
// ============================================================================
// wum_out_stage: result register
// Holds one result word until the consumer takes it.
// ============================================================================
`default_nettype none

module wum_out_stage
    import wum_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_result i_res,
    output logic         o_free,
    output logic         o_valid,
    input  wire logic    i_ready,
    output t_result      o_res
);

    logic    r_valid;
    t_result r_res;

    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_push;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_res <= i_res;
        end
    end

endmodule : wum_out_stage

`default_nettype wire

// File: rtl/core/wildcard_url_matcher_top.sv
// ============================================================================
// wildcard_url_matcher_top: anchored star-only wildcard matcher
// Pattern load and subject streaming, one byte per word, with a match result
// on the last subject byte.
// ============================================================================
// Usage: send pattern bytes with operation 0 (is_last on the final one), then
// subject bytes with operation 1; the word carrying the final subject byte
// returns one result word, all other words return none. '*' in the pattern
// matches any run of bytes, including none. Up to 64 pattern bytes are
// stored; a longer pattern reports pattern_too_long and never matches. A
// word is taken every cycle when the output side keeps up; the result word
// is registered in the result register once the final byte leaves the
// input register. The rate is set by the update of the 65-bit active
// position vector (64 byte compare lanes, then one carry chain for star runs).
`default_nettype none

module wildcard_url_matcher_top
    import wum_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic       i_operation,
    input  wire logic [7:0] i_char_byte,
    input  wire logic       i_is_last,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic            o_matched,
    output logic            o_pattern_too_long
);

    t_item   in_item, s_item;
    t_result s_res, out_res;
    logic    s_item_valid, s_pop, s_res_valid, s_out_free;

    always_comb begin
        in_item.operation = t_op'(i_operation);
        in_item.char_byte = i_char_byte;
        in_item.is_last   = i_is_last;
    end

    // Input register
    wum_in_stage u_in (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in_valid),
        .o_ready      (o_in_ready),
        .i_item       (in_item),
        .o_item_valid (s_item_valid),
        .o_item       (s_item),
        .i_pop        (s_pop)
    );

    // Match engine
    wum_engine u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (s_item_valid),
        .i_item       (s_item),
        .i_out_free   (s_out_free),
        .o_pop        (s_pop),
        .o_res_valid  (s_res_valid),
        .o_res        (s_res)
    );

    // Result register
    wum_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_res_valid),
        .i_res   (s_res),
        .o_free  (s_out_free),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_res   (out_res)
    );

    assign o_matched          = out_res.matched;
    assign o_pattern_too_long = out_res.pattern_too_long;

    // An overflowed pattern never reports a match
    a_no_match_on_overflow : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_matched && o_pattern_too_long))
        else $error("match reported with pattern overflow");

    // A held word that does not advance stays held
    a_hold_word : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_item_valid && !s_pop) |=> s_item_valid)
        else $error("input word lost while stalled");

    // Back-pressure only when the input register is occupied
    a_ready_when_empty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> s_item_valid)
        else $error("input stalled while empty");

    // A result is pushed only as its word leaves the input register
    a_push_with_pop : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_res_valid |-> (s_pop && s_out_free))
        else $error("result pushed without its word");

endmodule : wildcard_url_matcher_top

`default_nettype wire
